>>> hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge once reset is released
`define BMFP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BMFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/bmfp_pkg.sv
package bmfp_pkg;

  localparam int unsigned BitmapBytesDef     = 16;
  localparam int unsigned MaxPrefixDigitsDef = 3;

  localparam logic [7:0] HeaderLengthRst = 8'd46;

  // apb register map
  localparam int unsigned ApbAddrW       = 3;
  localparam logic        RegHeaderLength = 1'b0;

  // parser phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_TYPE   = 3'd2;
  localparam logic [2:0] PH_BITMAP = 3'd3;
  localparam logic [2:0] PH_FIELDS = 3'd4;
  localparam logic [2:0] PH_PREFIX = 3'd5;
  localparam logic [2:0] PH_BODY   = 3'd6;
  localparam logic [2:0] PH_ERROR  = 3'd7;

  // result kinds
  localparam logic [1:0] KIND_TYPE  = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // supported fields
  localparam logic [7:0] FIELD_LLVAR  = 8'd2;
  localparam logic [7:0] FIELD_FIX3   = 8'd23;
  localparam logic [7:0] FIELD_FIX8   = 8'd52;
  localparam logic [7:0] FIELD_LLLVAR = 8'd55;
  localparam logic [9:0] Fix3Len      = 10'd3;
  localparam logic [9:0] Fix8Len      = 10'd8;
  localparam logic [1:0] LlvarDigits  = 2'd2;

  localparam logic [7:0] TypeBytes   = 8'd4;
  localparam logic [7:0] NarrowBytes = 8'd8;
  localparam logic [7:0] WideBytes   = 8'd16;
  localparam logic [7:0] DigitZero   = 8'h30;
  localparam logic [7:0] DigitNine   = 8'h39;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } in_item_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [31:0] msg_type;
    logic [7:0]  field_num;
    logic [7:0]  fbyte;
    logic        last;
  } result_t;

endpackage

>>> hw/rtl/bmfp_cfg.sv
module bmfp_cfg import bmfp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output logic [7:0]          header_length_o
);

  logic [7:0] hdr_len_q, hdr_len_d;
  logic       wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == RegHeaderLength);

  always_comb begin
    hdr_len_d = hdr_len_q;
    if (wr_hit) begin
      hdr_len_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_len_q <= HeaderLengthRst;
    end else begin
      hdr_len_q <= hdr_len_d;
    end
  end

  assign prdata = (paddr[2] == RegHeaderLength) ? {24'd0, hdr_len_q} : 32'd0;
  assign header_length_o = hdr_len_q;

endmodule

>>> hw/rtl/bmfp_in_stage.sv
module bmfp_in_stage import bmfp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  input  logic     advance_i,
  output logic     item_valid_o,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> hw/rtl/bmfp_step.sv
module bmfp_step import bmfp_pkg::*; #(
  parameter int unsigned BITMAP_BYTES      = BitmapBytesDef,
  parameter int unsigned MAX_PREFIX_DIGITS = MaxPrefixDigitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_en_i,
  input  in_item_t   item_i,
  input  logic [7:0] header_length_i,
  output result_t    result_o
);

  localparam int unsigned BmBytes = (BITMAP_BYTES >= 16) ? 16 : 8;
  localparam int unsigned BmW     = BmBytes * 8;
  localparam int unsigned IdxW    = $clog2(BmW);
  localparam int unsigned LaneW   = $clog2(BmBytes);
  localparam logic        WideOk  = (BITMAP_BYTES >= 16);
  localparam logic [1:0]  LllDigits = 2'(MAX_PREFIX_DIGITS);

  logic [2:0]     ph_q, ph_d, ph_e;
  logic [7:0]     bc_q, bc_d, bc_e, bc_n;
  logic [31:0]    ts_q, ts_d, ts_e;
  logic [BmW-1:0] bm_q, bm_d, bm_e;
  logic           wide_q, wide_d, wide_e;
  logic [7:0]     cf_q, cf_d, cf_e;
  logic [9:0]     bl_q, bl_d, bl_e;
  logic [9:0]     lv_q, lv_d, lv_e;
  logic [1:0]     dl_q, dl_d, dl_e;
  logic           ds_q, ds_d, ds_e;

  logic [BmW-1:0] low_oh;
  logic [IdxW-1:0] low_idx;
  logic [7:0]     next_f;
  logic           has_field;
  logic [7:0]     total;
  logic [7:0]     b;

  // shared field byte step
  logic           fb_go, fb_prefix, fb_ds, fb_last;
  logic [1:0]     fb_dl;
  logic [9:0]     fb_bl, fb_lv, lv_new;
  logic           is_digit;

  assign b = item_i.data;

  always_comb begin
    if (item_i.first) begin
      ph_e   = (header_length_i == 8'd0) ? PH_TYPE : PH_HEADER;
      bc_e   = '0;
      ts_e   = '0;
      bm_e   = '0;
      wide_e = 1'b0;
      cf_e   = '0;
      bl_e   = '0;
      lv_e   = '0;
      dl_e   = '0;
      ds_e   = 1'b0;
    end else begin
      ph_e   = ph_q;
      bc_e   = bc_q;
      ts_e   = ts_q;
      bm_e   = bm_q;
      wide_e = wide_q;
      cf_e   = cf_q;
      bl_e   = bl_q;
      lv_e   = lv_q;
      dl_e   = dl_q;
      ds_e   = ds_q;
    end
  end

  // lowest set bitmap bit: isolate it, then encode the one-hot word
  always_comb begin
    low_oh    = bm_e & (~bm_e + BmW'(1));
    has_field = |bm_e;
    low_idx   = '0;
    for (int i = 0; i < IdxW; i++) begin
      for (int k = 0; k < BmW; k++) begin
        if (((k >> i) & 1) == 1) begin
          low_idx[i] = low_idx[i] | low_oh[k];
        end
      end
    end
    next_f = 8'(low_idx) + 8'd1;
  end

  always_comb begin
    ph_d      = ph_e;
    bc_d      = bc_e;
    ts_d      = ts_e;
    bm_d      = bm_e;
    wide_d    = wide_e;
    cf_d      = cf_e;
    bl_d      = bl_e;
    lv_d      = lv_e;
    dl_d      = dl_e;
    ds_d      = ds_e;
    result_o  = '0;
    bc_n      = bc_e + 8'd1;
    total     = NarrowBytes;
    fb_go     = 1'b0;
    fb_prefix = 1'b0;
    fb_dl     = dl_e;
    fb_bl     = bl_e;
    fb_lv     = lv_e;
    fb_ds     = ds_e;
    fb_last   = 1'b0;
    is_digit  = (b >= DigitZero) && (b <= DigitNine);
    lv_new    = '0;

    case (ph_e)
      PH_HEADER: begin
        if (bc_n == header_length_i) begin
          bc_d = '0;
          ph_d = PH_TYPE;
        end else begin
          bc_d = bc_n;
        end
      end
      PH_TYPE: begin
        ts_d = {ts_e[23:0], b};
        if (bc_n >= TypeBytes) begin
          bc_d              = '0;
          ph_d              = PH_BITMAP;
          result_o.valid    = 1'b1;
          result_o.kind     = KIND_TYPE;
          result_o.msg_type = ts_d;
        end else begin
          bc_d = bc_n;
        end
      end
      PH_BITMAP: begin
        if (bc_e == 8'd0) begin
          wide_d = WideOk & b[0];
        end
        for (int lane = 0; lane < BmBytes; lane++) begin
          if (bc_e[LaneW-1:0] == LaneW'(lane)) begin
            bm_d[lane*8 +: 8] = bm_d[lane*8 +: 8] | b;
          end
        end
        // secondary bitmap flag is never a field
        bm_d[0] = 1'b0;
        total   = wide_d ? WideBytes : NarrowBytes;
        if (bc_n >= total) begin
          bc_d = '0;
          ph_d = PH_FIELDS;
        end else begin
          bc_d = bc_n;
        end
      end
      PH_FIELDS: begin
        if (!has_field) begin
          ph_d = PH_IDLE;
        end else begin
          bm_d  = bm_e & ~low_oh;
          cf_d  = next_f;
          fb_lv = '0;
          fb_ds = 1'b0;
          lv_d  = '0;
          ds_d  = 1'b0;
          case (next_f)
            FIELD_LLVAR: begin
              fb_go     = 1'b1;
              fb_prefix = 1'b1;
              fb_dl     = LlvarDigits;
            end
            FIELD_LLLVAR: begin
              fb_go     = 1'b1;
              fb_prefix = 1'b1;
              fb_dl     = LllDigits;
            end
            FIELD_FIX3: begin
              fb_go = 1'b1;
              fb_bl = Fix3Len;
            end
            FIELD_FIX8: begin
              fb_go = 1'b1;
              fb_bl = Fix8Len;
            end
            default: begin
              ph_d               = PH_ERROR;
              result_o.valid     = 1'b1;
              result_o.kind      = KIND_ERROR;
              result_o.field_num = next_f;
            end
          endcase
        end
      end
      PH_PREFIX: begin
        fb_go     = 1'b1;
        fb_prefix = 1'b1;
      end
      PH_BODY: begin
        fb_go = 1'b1;
      end
      default: begin
      end
    endcase

    if (fb_go) begin
      if (fb_prefix) begin
        // length = 10 * length + digit, kept to 10 bits
        if (!fb_ds && is_digit) begin
          lv_new = {fb_lv[6:0], 3'b000} + {fb_lv[8:0], 1'b0} + {6'd0, b[3:0]};
          ds_d   = fb_ds;
        end else begin
          lv_new = fb_lv;
          ds_d   = 1'b1;
        end
        lv_d = lv_new;
        dl_d = fb_dl - 2'd1;
        if (dl_d == 2'd0) begin
          if (lv_new == 10'd0) begin
            fb_last = 1'b1;
            ph_d    = PH_FIELDS;
          end else begin
            bl_d = lv_new;
            ph_d = PH_BODY;
          end
        end else begin
          ph_d = PH_PREFIX;
        end
      end else begin
        bl_d = fb_bl - 10'd1;
        if (bl_d == 10'd0) begin
          fb_last = 1'b1;
          ph_d    = PH_FIELDS;
        end else begin
          ph_d = PH_BODY;
        end
      end
      result_o.valid     = 1'b1;
      result_o.kind      = KIND_FIELD;
      result_o.field_num = cf_d;
      result_o.fbyte     = b;
      result_o.last      = fb_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      bc_q   <= '0;
      ts_q   <= '0;
      bm_q   <= '0;
      wide_q <= 1'b0;
      cf_q   <= '0;
      bl_q   <= '0;
      lv_q   <= '0;
      dl_q   <= '0;
      ds_q   <= 1'b0;
    end else if (step_en_i) begin
      ph_q   <= ph_d;
      bc_q   <= bc_d;
      ts_q   <= ts_d;
      bm_q   <= bm_d;
      wide_q <= wide_d;
      cf_q   <= cf_d;
      bl_q   <= bl_d;
      lv_q   <= lv_d;
      dl_q   <= dl_d;
      ds_q   <= ds_d;
    end
  end

endmodule

>>> hw/rtl/bmfp_out_stage.sv
module bmfp_out_stage import bmfp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_en_i,
  input  result_t result_i,
  output logic    can_accept_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output result_t out_o
);

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  assign can_accept_o = !valid_q || out_ready_i;
  assign load         = step_en_i && result_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (can_accept_o) begin
      valid_d = load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

>>> hw/rtl/bitmap_message_field_parser.sv
// path: a byte goes to the input register, any result it gives to the output register
// throughput: one byte per cycle, sustained while the result side keeps taking
// transactions; the single-pass step logic between input and result registers sets it
// reset: rst_ni asynchronous active low; parser idle until a first-byte marker,
// output empty, header_length back to 46
module bitmap_message_field_parser import bmfp_pkg::*; #(
  parameter int unsigned BITMAP_BYTES      = BitmapBytesDef,
  parameter int unsigned MAX_PREFIX_DIGITS = MaxPrefixDigitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  logic                s_axis_tuser,   // [0] first_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,   // [31:0] message_type, [39:32] field_number,
                                              // [47:40] field_byte
  output logic [1:0]          m_axis_tuser,   // [1:0] kind
  output logic                m_axis_tlast,   // last_of_field
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [7:0] header_length;
  in_item_t   in_item, item;
  logic       item_valid;
  logic       can_accept;
  logic       step_en;
  result_t    step_res, out_res;

  assign in_item.data  = s_axis_tdata;
  assign in_item.first = s_axis_tuser;
  assign step_en       = item_valid && can_accept;

  bmfp_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .header_length_o(header_length)
  );

  bmfp_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .advance_i   (step_en),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  bmfp_step #(
    .BITMAP_BYTES     (BITMAP_BYTES),
    .MAX_PREFIX_DIGITS(MAX_PREFIX_DIGITS)
  ) u_step (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_en_i      (step_en),
    .item_i         (item),
    .header_length_i(header_length),
    .result_o       (step_res)
  );

  bmfp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step_en),
    .result_i    (step_res),
    .can_accept_o(can_accept),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_o       (out_res)
  );

  assign m_axis_tdata = {out_res.fbyte, out_res.field_num, out_res.msg_type};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

>>> hw/rtl/bmfp_chk.sv
`include "assert_macros.svh"

module bmfp_chk import bmfp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast,
  input logic        pready
);

  logic        out_wait;
  logic [50:0] out_bits;
  logic        type_clean;
  logic        error_clean;

  assign out_wait    = m_axis_tvalid && !m_axis_tready;
  assign out_bits    = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign type_clean  = (m_axis_tdata[47:32] == 16'd0) && !m_axis_tlast;
  assign error_clean = (m_axis_tdata[31:0] == 32'd0) && (m_axis_tdata[47:40] == 8'd0) &&
                       !m_axis_tlast && (m_axis_tdata[39:32] != 8'd0);

  `BMFP_ASSERT_ALWAYS(a_pready_high, clk_i, pready == 1'b1, "pready dropped")

  // the output register is cleared asynchronously while reset is low
  `BMFP_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |=> !m_axis_tvalid, "valid in reset")

  `BMFP_ASSERT(a_out_hold, clk_i, rst_ni, out_wait |=> m_axis_tvalid && $stable(out_bits), "stalled output transaction changed")

  `BMFP_ASSERT(a_kind_fields, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == KIND_TYPE |-> type_clean, "type result carries field data")

  `BMFP_ASSERT(a_error_fields, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == KIND_ERROR |-> error_clean, "malformed error result")

endmodule

bind bitmap_message_field_parser bmfp_chk u_bmfp_chk (.*);
